### hw/rtl/led_pwm_frame_engine_macros.svh
// Assertion macros used by the LED PWM frame engine RTL.
`ifndef LED_PWM_FRAME_ENGINE_MACROS_SVH
`define LED_PWM_FRAME_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define LPFE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpfe: assertion failed");
// Check on every clock edge, reset included.
`define LPFE_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lpfe: assertion failed");
`else
`define LPFE_ASSERT(name, prop)
`define LPFE_ASSERT_ALWAYS(name, prop)
`endif
`endif

### hw/rtl/lpfe_pkg.sv
// Types, constants and the timer period table of the LED PWM frame engine.
`default_nettype none
package lpfe_pkg;

  localparam int LedCountDef   = 19;
  localparam int SlotCountDef  = 64;
  localparam int BurstSlotsDef = 12;

  localparam int OffW    = 19;
  localparam int SlotW   = 6;
  localparam int PeriodW = 11;
  localparam int FrameW  = 8;
  localparam int IdxW    = 5;
  localparam int InLvlW  = 8;
  localparam int LevelW  = 7;

  localparam logic [InLvlW-1:0] MaxLevel      = 8'd64;
  localparam logic [2:0]        SwapFrameMask = 3'b111;

  typedef enum logic [1:0] {
    ReqSetLevel = 2'd0,
    ReqShow     = 2'd1,
    ReqTick     = 2'd2
  } req_e;

  // Level write into the back bank.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [LevelW-1:0] level;
  } wr_t;

  // One tick's work handed to the result generator.
  typedef struct packed {
    logic [SlotW-1:0]   first_slot;
    logic [SlotW-1:0]   last_slot;
    logic [PeriodW-1:0] period;
    logic [FrameW-1:0]  frame;
    logic               swap;
  } tick_t;

  localparam logic [PeriodW-1:0] PeriodTable [64] = '{
    11'd250,  11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd120,  11'd132,  11'd138,  11'd141,
    11'd145,  11'd149,  11'd154,  11'd158,  11'd163,  11'd168,  11'd174,  11'd180,
    11'd186,  11'd193,  11'd200,  11'd207,  11'd215,  11'd223,  11'd232,  11'd242,
    11'd252,  11'd263,  11'd274,  11'd286,  11'd299,  11'd313,  11'd327,  11'd343,
    11'd359,  11'd376,  11'd395,  11'd414,  11'd435,  11'd457,  11'd481,  11'd506,
    11'd532,  11'd561,  11'd591,  11'd622,  11'd656,  11'd692,  11'd730,  11'd771,
    11'd814,  11'd859,  11'd908,  11'd959,  11'd1014, 11'd1072, 11'd1134, 11'd1200
  };

  function automatic logic [PeriodW-1:0] period_lookup(input logic [SlotW-1:0] slot);
    return PeriodTable[slot];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/led_pwm_frame_engine.sv
// LED PWM frame engine: request decode, slot and frame counters, swap control.
// Input channel: in_valid_i / in_stall_o carry one request word (req_type_i,
// led_index_i, level_value_i). A set writes a level, clamped to 64, into the
// back bank; a show arms a bank swap; a tick shows PWM slots.
// Output channel: out_valid_o / out_stall_i carry one result word per slot:
// active-low LED pattern, slot, timer period, frame number and last flag.
// A tick at slot 0 gives BURST_SLOTS words on consecutive cycles while the
// receiver does not stall; any other tick gives one word. Sets, shows and
// unused codes give none. Words pass the generator, then the output register.
// Throughput: one request per cycle while the input is not stalled; a slot-0
// tick stalls the input until its last word issues, while the burst generator
// feeds the output register one word a cycle unless the receiver stalls.
// An armed swap takes effect after the last word of the tick that wraps the
// frame counter onto a multiple of eight.
// Reset clears both banks, the counters and the pending swap; no output is
// valid after reset. While the receiver stalls a held word, the output register
// holds and the generator waits; input stalls only while a tick's words remain.
`default_nettype none
module led_pwm_frame_engine #(
  parameter int LED_COUNT   = lpfe_pkg::LedCountDef,
  parameter int SLOT_COUNT  = lpfe_pkg::SlotCountDef,
  parameter int BURST_SLOTS = lpfe_pkg::BurstSlotsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [lpfe_pkg::IdxW-1:0]    led_index_i,
  input  wire logic [lpfe_pkg::InLvlW-1:0]  level_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [lpfe_pkg::OffW-1:0]    led_off_bits_o,
  output logic      [lpfe_pkg::SlotW-1:0]   slot_index_o,
  output logic      [lpfe_pkg::PeriodW-1:0] next_period_o,
  output logic      [lpfe_pkg::FrameW-1:0]  frame_number_o,
  output logic                              last_of_run_o
);

  logic                         accept;
  logic                         busy;
  logic                         swap_fire;
  logic [lpfe_pkg::SlotW-1:0]   gen_slot;
  logic [lpfe_pkg::OffW-1:0]    led_off;
  logic [lpfe_pkg::SlotW-1:0]   slot_q, slot_d;
  logic [lpfe_pkg::FrameW-1:0]  frame_q, frame_d;
  logic                         pending_q, pending_d;
  logic [lpfe_pkg::SlotW:0]     next_slot;
  logic                         wrap;
  logic                         load;
  lpfe_pkg::wr_t                wr;
  lpfe_pkg::tick_t              tick;
  lpfe_pkg::req_e               req;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign req        = lpfe_pkg::req_e'(req_type_i);

  always_comb begin
    next_slot = (slot_q == '0) ? 7'(BURST_SLOTS) : ({1'b0, slot_q} + 7'd1);
    wrap      = (next_slot >= 7'(SLOT_COUNT));

    wr.en    = 1'b0;
    wr.idx   = led_index_i;
    wr.level = (level_value_i > lpfe_pkg::MaxLevel) ? lpfe_pkg::MaxLevel[6:0]
                                                    : level_value_i[6:0];

    slot_d    = slot_q;
    frame_d   = frame_q;
    pending_d = pending_q;
    load      = 1'b0;

    tick.first_slot = slot_q;
    tick.last_slot  = (slot_q == '0) ? 6'(BURST_SLOTS - 1) : slot_q;
    tick.period     = lpfe_pkg::period_lookup(slot_q);
    tick.frame      = wrap ? (frame_q + 8'd1) : frame_q;
    tick.swap       = wrap && pending_q
                      && ((tick.frame[2:0] & lpfe_pkg::SwapFrameMask) == 3'b000);

    if (accept) begin
      case (req)
        lpfe_pkg::ReqSetLevel: begin
          wr.en = 1'b1;
        end
        lpfe_pkg::ReqShow: begin
          pending_d = 1'b1;
        end
        lpfe_pkg::ReqTick: begin
          load    = 1'b1;
          slot_d  = wrap ? '0 : next_slot[lpfe_pkg::SlotW-1:0];
          frame_d = tick.frame;
          // drop the pending flag now; the banks flip after the last word
          if (tick.swap) begin
            pending_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      frame_q   <= '0;
      pending_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      frame_q   <= frame_d;
      pending_q <= pending_d;
    end
  end

  lpfe_banks #(
    .LED_COUNT(LED_COUNT)
  ) u_banks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .swap_i    (swap_fire),
    .slot_i    (gen_slot),
    .led_off_o (led_off)
  );

  lpfe_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .tick_i         (tick),
    .led_off_i      (led_off),
    .slot_o         (gen_slot),
    .busy_o         (busy),
    .swap_o         (swap_fire),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_off_bits_o (led_off_bits_o),
    .slot_index_o   (slot_index_o),
    .next_period_o  (next_period_o),
    .frame_number_o (frame_number_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

### hw/rtl/lpfe_banks.sv
// Front and back level banks with the per-slot dark pattern.
`default_nettype none
module lpfe_banks #(
  parameter int LED_COUNT = lpfe_pkg::LedCountDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lpfe_pkg::wr_t               wr_i,
  input  wire logic                        swap_i,
  input  wire logic [lpfe_pkg::SlotW-1:0]  slot_i,
  output logic      [lpfe_pkg::OffW-1:0]   led_off_o
);

  logic [lpfe_pkg::LevelW-1:0] front_q [LED_COUNT];
  logic [lpfe_pkg::LevelW-1:0] back_q  [LED_COUNT];

  // The new front is the old back; the back keeps its copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        front_q[i] <= '0;
        back_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        if (swap_i) begin
          front_q[i] <= back_q[i];
        end
        if (wr_i.en && ({1'b0, wr_i.idx} == 6'(i))) begin
          back_q[i] <= wr_i.level;
        end
      end
    end
  end

  always_comb begin
    led_off_o = '0;
    for (int i = 0; i < lpfe_pkg::OffW; i++) begin
      if (i < LED_COUNT) begin
        led_off_o[i] = !(front_q[i] > {1'b0, slot_i});
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lpfe_emit.sv
// Result generator and output register: one result word per cycle unless the receiver stalls.
`default_nettype none
`include "led_pwm_frame_engine_macros.svh"
module lpfe_emit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire lpfe_pkg::tick_t              tick_i,
  input  wire logic [lpfe_pkg::OffW-1:0]    led_off_i,
  output logic      [lpfe_pkg::SlotW-1:0]   slot_o,
  output logic                              busy_o,
  output logic                              swap_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [lpfe_pkg::OffW-1:0]    led_off_bits_o,
  output logic      [lpfe_pkg::SlotW-1:0]   slot_index_o,
  output logic      [lpfe_pkg::PeriodW-1:0] next_period_o,
  output logic      [lpfe_pkg::FrameW-1:0]  frame_number_o,
  output logic                              last_of_run_o
);

  logic                         gen_valid_q;
  logic [lpfe_pkg::SlotW-1:0]   gen_slot_q;
  logic [lpfe_pkg::SlotW-1:0]   gen_end_q;
  logic [lpfe_pkg::PeriodW-1:0] gen_period_q;
  logic [lpfe_pkg::FrameW-1:0]  gen_frame_q;
  logic                         gen_swap_q;
  logic                         out_valid_q;
  logic                         issue;
  logic                         last_slot;

  assign issue     = gen_valid_q && (!out_valid_q || !out_stall_i);
  assign last_slot = (gen_slot_q == gen_end_q);
  assign busy_o    = gen_valid_q && !(issue && last_slot);
  assign swap_o    = issue && last_slot && gen_swap_q;
  assign slot_o    = gen_slot_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        gen_valid_q <= 1'b1;
      end else if (issue && last_slot) begin
        gen_valid_q <= 1'b0;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: load a new tick, or advance through the burst.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      gen_slot_q   <= tick_i.first_slot;
      gen_end_q    <= tick_i.last_slot;
      gen_period_q <= tick_i.period;
      gen_frame_q  <= tick_i.frame;
      gen_swap_q   <= tick_i.swap;
    end else if (issue && !last_slot) begin
      gen_slot_q <= gen_slot_q + 6'd1;
    end
    if (issue) begin
      led_off_bits_o <= led_off_i;
      slot_index_o   <= gen_slot_q;
      next_period_o  <= gen_period_q;
      frame_number_o <= gen_frame_q;
      last_of_run_o  <= last_slot;
    end
  end

  `LPFE_ASSERT(a_slot_in_run, !(gen_valid_q && (gen_slot_q > gen_end_q)))
  `LPFE_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> (!gen_valid_q && !out_valid_q))
  `LPFE_ASSERT(a_load_when_free, load_i |-> (!gen_valid_q || (issue && last_slot)))
  `LPFE_ASSERT(a_burst_advance,
    (issue && !last_slot) |=> (gen_valid_q && (gen_slot_q == $past(gen_slot_q) + 6'd1)))

endmodule
`default_nettype wire
